// ===== src/histogram_accumulator_macros.svh =====
// Assertion macros shared by the histogram accumulator modules.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef HISTOGRAM_ACCUMULATOR_MACROS_SVH
`define HISTOGRAM_ACCUMULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent and consequent hold in the same cycle.
`define HACC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define HACC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HACC_ASSERT_SAME(label, ante, cons, msg)
`define HACC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/hacc_pkg.sv =====
`default_nettype none

package hacc_pkg;

  // Operation codes of a request transaction.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;

  // Request payload.
  typedef struct packed {
    logic        op;
    logic [15:0] sample_index;
  } hacc_in_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] bin_value;
    logic [31:0] samples_total;
    logic [47:0] index_sum;
    logic [9:0]  highest_index;
    logic [31:0] peak_count;
  } hacc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the index and read its bin
    logic update;     // write back the bin and update statistics
    logic oor;        // report an out-of-range sample
    logic clr_start;  // zero statistics and arm the bin sweep
    logic sweep;      // zero one bin
    logic clr_done;   // report a finished clear
  } hacc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic sweep_last;
  } hacc_stat_t;

endpackage

`default_nettype wire

// ===== src/hacc_dpath.sv =====
`default_nettype none
`include "histogram_accumulator_macros.svh"

module hacc_dpath #(
  parameter int BINS        = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hacc_pkg::hacc_in_t request,
  input  wire hacc_pkg::hacc_cmd_t cmd,
  output hacc_pkg::hacc_stat_t    stat,
  output hacc_pkg::hacc_out_t     result
);

  localparam int IDX_W = $clog2(BINS);
  localparam logic [IDX_W-1:0] LastBin = IDX_W'(BINS - 1);
  localparam logic [16:0] BinsExt = 17'(BINS);

  // Bin memory and its registered read port.
  logic [COUNT_WIDTH-1:0] mem [BINS];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]       idx_reg;

  // Running statistics.
  logic [IDX_W-1:0]       top_index;
  logic [COUNT_WIDTH-1:0] top_count;
  logic [COUNT_WIDTH-1:0] sample_total;
  logic [47:0]            sum_of_indices;

  // Clear sweep pointer and its last address.
  logic [IDX_W-1:0] sweep_addr;
  logic [IDX_W-1:0] sweep_limit;

  logic [COUNT_WIDTH-1:0] bin_next;
  logic [COUNT_WIDTH-1:0] total_next;
  logic [47:0]            sum_next;
  logic [48:0]            sum_wide;
  logic [IDX_W-1:0]       top_index_next;
  logic [COUNT_WIDTH-1:0] top_count_next;

  logic [COUNT_WIDTH-1:0] view_bin;
  logic [COUNT_WIDTH-1:0] view_total;
  logic [47:0]            view_sum;
  logic [IDX_W-1:0]       view_top_index;
  logic [COUNT_WIDTH-1:0] view_top_count;
  logic [63:0]            bin_w;
  logic [63:0]            total_w;
  logic [63:0]            peak_w;
  logic [15:0]            top_w;

  // Range check of the incoming index.
  assign stat.in_range   = ({1'b0, request.sample_index} < BinsExt);
  assign stat.sweep_last = (sweep_addr == sweep_limit);

  // Saturating updates of the bin, the sample total and the index sum; running maxima of index and count.
  always_comb begin
    bin_next       = (&rd_data) ? rd_data : rd_data + 1'b1;
    total_next     = (&sample_total) ? sample_total : sample_total + 1'b1;
    sum_wide       = {1'b0, sum_of_indices} + 49'(idx_reg);
    sum_next       = sum_wide[48] ? '1 : sum_wide[47:0];
    top_index_next = (idx_reg > top_index) ? idx_reg : top_index;
    top_count_next = (bin_next > top_count) ? bin_next : top_count;
  end

  // Values shown in a counted or out-of-range result.
  always_comb begin
    view_bin       = cmd.update ? bin_next : '0;
    view_total     = cmd.update ? total_next : sample_total;
    view_sum       = cmd.update ? sum_next : sum_of_indices;
    view_top_index = cmd.update ? top_index_next : top_index;
    view_top_count = cmd.update ? top_count_next : top_count;
    bin_w          = 64'(view_bin);
    total_w        = 64'(view_total);
    peak_w         = 64'(view_top_count);
    top_w          = 16'(view_top_index);
  end

  // Bin memory write port: sweep zeroes, update writes back.
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_addr] <= '0;
    end else if (cmd.update) begin
      mem[idx_reg] <= bin_next;
    end
  end

  // Bin memory read port, taken with the request transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= mem[request.sample_index[IDX_W-1:0]];
      idx_reg <= request.sample_index[IDX_W-1:0];
    end
  end

  // Sweep pointer; reset arms a sweep over every bin.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr  <= '0;
      sweep_limit <= LastBin;
    end else if (cmd.clr_start) begin
      sweep_addr  <= '0;
      sweep_limit <= top_index;
    end else if (cmd.sweep && !stat.sweep_last) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // Statistics registers.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      top_index      <= '0;
      top_count      <= '0;
      sample_total   <= '0;
      sum_of_indices <= '0;
    end else if (cmd.update) begin
      top_index      <= top_index_next;
      top_count      <= top_count_next;
      sample_total   <= total_next;
      sum_of_indices <= sum_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    priority if (cmd.clr_done) begin
      result.status        <= hacc_pkg::ST_CLEARED;
      result.bin_value     <= '0;
      result.samples_total <= '0;
      result.index_sum     <= '0;
      result.highest_index <= '0;
      result.peak_count    <= '0;
    end else if (cmd.update || cmd.oor) begin
      result.status        <= cmd.update ? hacc_pkg::ST_COUNTED : hacc_pkg::ST_RANGE;
      result.bin_value     <= bin_w[31:0];
      result.samples_total <= total_w[31:0];
      result.index_sum     <= view_sum;
      result.highest_index <= top_w[9:0];
      result.peak_count    <= peak_w[31:0];
    end
  end

  `HACC_ASSERT_SAME(a_sweep_bound, cmd.sweep, sweep_addr <= sweep_limit, "sweep past limit")
  `HACC_ASSERT_NEXT(a_clear_zero, cmd.clr_start, sample_total == '0 && top_index == '0, "stats kept")

endmodule

`default_nettype wire

// ===== src/hacc_ctrl.sv =====
`default_nettype none
`include "histogram_accumulator_macros.svh"

module hacc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 op,
  input  wire hacc_pkg::hacc_stat_t stat,
  output hacc_pkg::hacc_cmd_t       cmd,
  output logic                      busy,
  output logic                      done
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   report;
  logic   report_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (op == hacc_pkg::OP_CLEAR) begin
            cmd.clr_start = 1'b1;
            report_next   = 1'b1;
            state_next    = S_SWEEP;
          end else if (stat.in_range) begin
            cmd.capture = 1'b1;
            state_next  = S_UPDATE;
          end else begin
            cmd.oor = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.clr_done = report;
          state_next   = S_IDLE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, sweep report flag and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      report <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
      done   <= cmd.update || cmd.oor || cmd.clr_done;
    end
  end

  // The finished-clear report rides along with the last sweep command, so it is
  // left out of the one-command check (it is the lowest bit of the command).
  `HACC_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
  `HACC_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd[5:1]), "several commands at once")
  `HACC_ASSERT_NEXT(a_clear_busy, accept && op == hacc_pkg::OP_CLEAR, busy && !done, "clear not swept")

endmodule

`default_nettype wire

// ===== src/histogram_accumulator.sv =====
`default_nettype none
// Channel   Signals                     Transaction
// request   start, busy, request        taken at an edge with start high and busy low
// result    done, result                one cycle long, taken at the edge ending it
//
// An in-range sample reads its bin, then writes it back with busy high.
// An out-of-range sample leaves busy low.
// A clear zeroes bins 0 to the highest counted index, one bin a cycle.
// After reset the block sweeps all BINS bins with busy high and gives no result.
// The result for a busy transaction shows in the cycle after its last busy cycle.

module histogram_accumulator #(
  parameter int BINS        = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire hacc_pkg::hacc_in_t request,
  output logic                    done,
  output hacc_pkg::hacc_out_t     result
);

  hacc_pkg::hacc_cmd_t  cmd;
  hacc_pkg::hacc_stat_t stat;

  // Sequencing of request transactions and clear sweeps.
  hacc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (request.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Bin memory, statistics and result register.
  hacc_dpath #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

`default_nettype wire
